// File: hdl/bdq_pkg.sv
package bdq_pkg;

    // Ring geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    // Operation codes
    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_COUNT      = 3'd4,
        FN_ERASE      = 3'd5
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef struct packed {
        t_func              func;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] popped_value;
        logic [4:0]         match_count;
        logic [4:0]         occupancy;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
    } t_out_item;

endpackage

// File: hdl/bounded_deque_with_match_erase.sv
// Bounded double-ended queue of 32-bit signed words with count and erase by key.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction asks for
// push front, push back, pop front, pop back, count key or erase key.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
// per input transaction, with status, popped value, match count, occupancy and
// the front and back entries after the operation.
//
// Count and erase walk every entry present before the operation, and a pop or erase on
// an empty queue skips its walk or read; after that front and back are read in turn.
// The ring has a single read port, so every entry visited takes one read.
// One operation is in flight at a time and o_in_ready is high only while idle,
// so a new transaction is taken only once the previous one has left S_DONE.
// Reset (synchronous, active low) empties the queue and drops any pending
// result. A stalled receiver holds the finished result in the output register;
// a new transaction may still be accepted, and its result waits until the
// previous one has been taken.
module bounded_deque_with_match_erase
    import bdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WB,
        S_WALK,
        S_FRONT,
        S_BACK,
        S_DONE
    } t_state;

    // Ring slot of a position counted from the head
    function automatic logic [IDX_W-1:0] f_slot(input logic [IDX_W-1:0] h,
                                                input logic [IDX_W-1:0] p);
        logic [IDX_W:0] s;
        s = {1'b0, h} + {1'b0, p};
        if (s >= (IDX_W+1)'(DEPTH)) begin
            s = s - (IDX_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // Low five bits of a count
    function automatic logic [4:0] f_to5(input logic [CNT_W-1:0] c);
        logic [CNT_W+4:0] t;
        t = {5'b0, c};
        return t[4:0];
    endfunction

    // Ring memory
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic [IDX_W-1:0]  rd_addr;
    logic              w_en;
    logic [IDX_W-1:0]  w_addr;
    logic [WORD_W-1:0] w_data;

    // Control and payload registers
    t_state            r_state,     n_state;
    logic [IDX_W-1:0]  r_head,      n_head;
    logic [CNT_W-1:0]  r_cnt,       n_cnt;
    t_func             r_func,      n_func;
    logic [WORD_W-1:0] r_key,       n_key;
    t_status           r_status,    n_status;
    logic [WORD_W-1:0] r_popped,    n_popped;
    logic [CNT_W-1:0]  r_matches,   n_matches;
    logic [CNT_W-1:0]  r_idx,       n_idx;
    logic [CNT_W-1:0]  r_kept,      n_kept;
    logic              r_rvld,      n_rvld;
    logic [WORD_W-1:0] r_front,     n_front;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,       n_out;

    logic              full;
    logic              empty;
    logic [IDX_W-1:0]  head_dec;
    logic [IDX_W-1:0]  last_pos;
    logic              more;

    assign full     = (r_cnt >= CNT_W'(DEPTH));
    assign empty    = (r_cnt == '0);
    assign head_dec = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - IDX_W'(1);
    assign last_pos = IDX_W'(r_cnt - CNT_W'(1));
    assign more     = (r_idx < r_cnt);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer and datapath
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_func      = r_func;
        n_key       = r_key;
        n_status    = r_status;
        n_popped    = r_popped;
        n_matches   = r_matches;
        n_idx       = r_idx;
        n_kept      = r_kept;
        n_rvld      = r_rvld;
        n_front     = r_front;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        rd_addr     = r_head;
        w_en        = 1'b0;
        w_addr      = r_head;
        w_data      = r_key;

        // result taken by the receiver
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_in_data.func;
                    n_key   = i_in_data.value;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status  = ST_OK;
                n_popped  = '0;
                n_matches = '0;
                n_idx     = '0;
                n_kept    = '0;
                n_rvld    = 1'b0;
                n_state   = S_FRONT;
                case (r_func)
                    FN_PUSH_FRONT: begin
                        if (full) begin
                            n_status = ST_OVER;
                        end else begin
                            w_en   = 1'b1;
                            w_addr = head_dec;
                            n_head = head_dec;
                            n_cnt  = r_cnt + CNT_W'(1);
                        end
                    end
                    FN_PUSH_BACK: begin
                        if (full) begin
                            n_status = ST_OVER;
                        end else begin
                            w_en   = 1'b1;
                            w_addr = f_slot(r_head, r_cnt[IDX_W-1:0]);
                            n_cnt  = r_cnt + CNT_W'(1);
                        end
                    end
                    FN_POP_FRONT: begin
                        if (empty) begin
                            n_status = ST_UNDER;
                        end else begin
                            rd_addr = r_head;
                            n_state = S_POP_WB;
                        end
                    end
                    FN_POP_BACK: begin
                        if (empty) begin
                            n_status = ST_UNDER;
                        end else begin
                            rd_addr = f_slot(r_head, last_pos);
                            n_state = S_POP_WB;
                        end
                    end
                    FN_COUNT: begin
                        n_state = S_WALK;
                    end
                    FN_ERASE: begin
                        if (empty) begin
                            n_status = ST_UNDER;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        n_state = S_FRONT;
                    end
                endcase
            end

            S_POP_WB: begin
                n_popped = r_rd_data;
                n_cnt    = r_cnt - CNT_W'(1);
                if (r_func == FN_POP_FRONT) begin
                    n_head = f_slot(r_head, IDX_W'(1));
                end
                n_state = S_FRONT;
            end

            S_WALK: begin
                // issue the next read
                if (more) begin
                    rd_addr = f_slot(r_head, r_idx[IDX_W-1:0]);
                    n_idx   = r_idx + CNT_W'(1);
                    n_rvld  = 1'b1;
                end else begin
                    n_rvld  = 1'b0;
                end
                // compare the entry read last cycle; survivors close up
                if (r_rvld) begin
                    if (r_rd_data == r_key) begin
                        n_matches = r_matches + CNT_W'(1);
                    end else if (r_func == FN_ERASE) begin
                        w_en   = 1'b1;
                        w_addr = f_slot(r_head, r_kept[IDX_W-1:0]);
                        w_data = r_rd_data;
                        n_kept = r_kept + CNT_W'(1);
                    end
                end
                // walk complete
                if (!more && !r_rvld) begin
                    if (r_func == FN_ERASE) begin
                        n_cnt = r_kept;
                        if (r_kept == '0) begin
                            n_head = '0;
                        end
                    end
                    n_state = S_FRONT;
                end
            end

            S_FRONT: begin
                rd_addr = r_head;
                n_state = S_BACK;
            end

            S_BACK: begin
                n_front = r_rd_data;
                rd_addr = f_slot(r_head, last_pos);
                n_state = S_DONE;
            end

            S_DONE: begin
                // back entry is on the read port; keep re-reading it while stalled
                rd_addr = f_slot(r_head, last_pos);
                if (!r_out_valid || i_out_ready) begin
                    n_out.status       = r_status;
                    n_out.popped_value = r_popped;
                    n_out.match_count  = f_to5(r_matches);
                    n_out.occupancy    = f_to5(r_cnt);
                    n_out.front_value  = empty ? '0 : r_front;
                    n_out.back_value   = empty ? '0 : r_rd_data;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_cnt       <= '0;
            r_rvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_rvld      <= n_rvld;
            r_out_valid <= n_out_valid;
        end
        r_func    <= n_func;
        r_key     <= n_key;
        r_status  <= n_status;
        r_popped  <= n_popped;
        r_matches <= n_matches;
        r_idx     <= n_idx;
        r_kept    <= n_kept;
        r_front   <= n_front;
        r_out     <= n_out;
    end

    // Ring memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    import bdq_pkg::*;

    localparam int RAND_ITEMS  = 400;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 30;

    // Stimulus entry: one transaction plus a flag asking the driver to drain first
    typedef struct {
        t_in_item item;
        bit       hold;
    } t_stim;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    t_stim     stim_q[$];
    t_out_item expected_q[$];

    // Shadow of the deque: ring, head and occupancy
    logic signed [WORD_W-1:0] mdl_ring [DEPTH];
    logic [IDX_W-1:0]         mdl_head = '0;
    logic [CNT_W-1:0]         mdl_cnt = '0;

    int err_cnt     = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int total_items = 0;
    int n_under     = 0;
    int n_over      = 0;
    int n_full      = 0;
    int n_wiped     = 0;
    int cyc         = 0;
    int n_op[6]     = '{default: 0};

    int send_idle_pct[3] = '{10, 56, 0};
    int recv_idle_pct[3] = '{56, 10, 0};

    bounded_deque_with_match_erase dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idling regime follows progress through the stimulus
    function automatic int pace_phase();
        if (total_items == 0)
            return 0;
        return (n_accepted * 3 / total_items > 2) ? 2 : n_accepted * 3 / total_items;
    endfunction

    function automatic int ring_slot(int pos);
        return (int'(mdl_head) + pos) % DEPTH;
    endfunction

    // Apply one transaction to the shadow deque and work out its result
    function automatic t_out_item deque_apply(t_in_item it);
        t_out_item                r;
        logic signed [WORD_W-1:0] e;
        int                       kept;
        int                       hits;
        r = '0;
        r.status = ST_OK;
        hits = 0;
        case (it.func)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (int'(mdl_cnt) >= DEPTH) begin
                    r.status = ST_OVER;
                end else if (it.func == FN_PUSH_FRONT) begin
                    mdl_head = IDX_W'((int'(mdl_head) + DEPTH - 1) % DEPTH);
                    mdl_ring[mdl_head] = it.value;
                    mdl_cnt++;
                end else begin
                    mdl_ring[ring_slot(int'(mdl_cnt))] = it.value;
                    mdl_cnt++;
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                if (mdl_cnt == 0) begin
                    r.status = ST_UNDER;
                end else if (it.func == FN_POP_FRONT) begin
                    r.popped_value = mdl_ring[mdl_head];
                    mdl_head = IDX_W'(ring_slot(1));
                    mdl_cnt--;
                end else begin
                    r.popped_value = mdl_ring[ring_slot(int'(mdl_cnt) - 1)];
                    mdl_cnt--;
                end
            end
            FN_COUNT: begin
                for (int i = 0; i < int'(mdl_cnt); i++)
                    if (mdl_ring[ring_slot(i)] == it.value)
                        hits++;
            end
            FN_ERASE: begin
                if (mdl_cnt == 0) begin
                    r.status = ST_UNDER;
                end else begin
                    // compact survivors towards the head, order kept
                    kept = 0;
                    for (int i = 0; i < int'(mdl_cnt); i++) begin
                        e = mdl_ring[ring_slot(i)];
                        if (e == it.value) begin
                            hits++;
                        end else begin
                            mdl_ring[ring_slot(kept)] = e;
                            kept++;
                        end
                    end
                    mdl_cnt = CNT_W'(kept);
                    if (kept == 0)
                        mdl_head = '0;
                end
            end
            default: ;
        endcase
        r.match_count = 5'(hits);
        r.occupancy   = 5'(mdl_cnt);
        if (mdl_cnt != 0) begin
            r.front_value = mdl_ring[mdl_head];
            r.back_value  = mdl_ring[ring_slot(int'(mdl_cnt) - 1)];
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    task automatic queue_op(t_func f, logic signed [31:0] v, bit hold = 1'b0);
        t_stim s;
        s.item.func  = f;
        s.item.value = v;
        s.hold       = hold;
        stim_q.push_back(s);
    endtask

    // Mostly a small pool so that keys repeat, some extremes, some fully random
    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] pool[4];
        int                 roll;
        pool = '{32'sd3, -32'sd7, 32'sd42, -32'sd1};
        roll = $urandom_range(9);
        if (roll < 6)
            return pool[$urandom_range(3)];
        if (roll < 8)
            return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return $urandom;
    endfunction

    // Driver: predicts on each accepted transaction, then presents the next one
    always @(posedge i_clk) begin : driver
        t_out_item pred;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                pred = deque_apply(in_data);
                expected_q.push_back(pred);
                n_op[int'(in_data.func)]++;
                n_accepted++;
                if (pred.status == ST_UNDER)
                    n_under++;
                if (pred.status == ST_OVER)
                    n_over++;
                if (int'(pred.occupancy) == DEPTH)
                    n_full++;
                if (in_data.func == FN_ERASE && pred.status == ST_OK && pred.occupancy == 0)
                    n_wiped++;
            end
            if (!in_valid || in_ready) begin
                if (stim_q.size() != 0
                        && $urandom_range(99) >= send_idle_pct[pace_phase()]
                        && !(stim_q[0].hold && expected_q.size() != 0)) begin
                    in_valid <= 1'b1;
                    in_data  <= stim_q[0].item;
                    stim_q.delete(0);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    $error("result with no transaction outstanding");
                    err_cnt++;
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    check_field("status", 32'(want.status), 32'(out_data.status));
                    check_field("popped_value", want.popped_value, out_data.popped_value);
                    check_field("match_count", 32'(want.match_count),
                                32'(out_data.match_count));
                    check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
                    check_field("front_value", want.front_value, out_data.front_value);
                    check_field("back_value", want.back_value, out_data.back_value);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct[pace_phase()]);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cyc, expected_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic signed [31:0] extremes[4];
        logic signed [31:0] key;
        int                 n_rand;
        int                 mode;
        int                 burst;
        int                 reps;
        int                 roll;
        int                 push_pct[3];
        int                 pop_pct[3];
        bit                 hold;

        extremes = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1};
        push_pct = '{75, 15, 35};
        pop_pct  = '{15, 75, 25};
        key = 32'sh0000_5A5A;

        // Directed: pops, erase and count on the empty queue
        queue_op(FN_POP_FRONT, 32'sd0);
        queue_op(FN_POP_BACK, 32'sd0);
        queue_op(FN_ERASE, key);
        queue_op(FN_COUNT, key);
        // fill to the brim from both ends, key at head and at tail
        for (int i = 0; i < DEPTH; i++)
            queue_op(i[0] ? FN_PUSH_FRONT : FN_PUSH_BACK,
                     (i % 3 == 0 || i >= DEPTH - 2) ? key : extremes[i % 4]);
        // pushes into a full queue are dropped
        queue_op(FN_PUSH_FRONT, 32'sh7FFF_FFFF);
        queue_op(FN_PUSH_BACK, 32'sh8000_0000);
        queue_op(FN_COUNT, key);
        queue_op(FN_ERASE, key);
        queue_op(FN_POP_FRONT, 32'sd0);
        queue_op(FN_POP_BACK, 32'sd0);

        // Random bursts: fill-heavy, drain-heavy, mixed, and runs of one key then count and erase
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            hold  = (n_rand == 0) || ($urandom_range(19) == 0);
            mode  = $urandom_range(3);
            burst = $urandom_range(24, 8);
            if (mode == 3) begin
                key  = rand_word();
                reps = $urandom_range(DEPTH, 1);
                for (int i = 0; i < reps; i++)
                    queue_op($urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT, key,
                             hold && i == 0);
                queue_op(FN_COUNT, key);
                queue_op(FN_ERASE, key);
                n_rand += reps + 2;
            end else begin
                for (int i = 0; i < burst; i++) begin
                    roll = $urandom_range(99);
                    if (roll < push_pct[mode])
                        queue_op($urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT,
                                 rand_word(), hold && i == 0);
                    else if (roll < push_pct[mode] + pop_pct[mode])
                        queue_op($urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT,
                                 rand_word(), hold && i == 0);
                    else
                        queue_op($urandom_range(1) ? FN_ERASE : FN_COUNT,
                                 rand_word(), hold && i == 0);
                end
                n_rand += burst;
            end
        end
        total_items = stim_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all stimulus taken, every result back, then a quiet tail
        while (stim_q.size() != 0 || in_valid)
            @(posedge i_clk);
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d transactions, %0d results: push f/b %0d/%0d, pop f/b %0d/%0d",
                 n_accepted, n_results, n_op[FN_PUSH_FRONT], n_op[FN_PUSH_BACK],
                 n_op[FN_POP_FRONT], n_op[FN_POP_BACK]);
        $display("%0d count, %0d erase, %0d under, %0d over, %0d full, %0d wiped, %0d errors",
                 n_op[FN_COUNT], n_op[FN_ERASE], n_under, n_over, n_full, n_wiped,
                 err_cnt);
        if (err_cnt == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
